// File: rtl/lssd_pkg.sv
// Package for the LIFO stack with search and delete.
// Holds the operation and status codes, the transfer structs and the
// controller/datapath command and status types. No dependencies.
package lssd_pkg;

    // Operation codes carried in the action field
    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Request transfer
    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value_in;
    } req_t;

    // Response transfer
    typedef struct packed {
        logic signed [31:0] value_out;
        status_t            status;
        logic [4:0]         entries_held;
    } rsp_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP_WAIT,
        S_SEARCH,
        S_SHIFT,
        S_FINISH
    } state_t;

    // Read address source
    typedef enum logic [1:0] {
        RD_TOP,
        RD_DOWN,
        RD_UP1,
        RD_UP2
    } rd_sel_t;

    // Scan pointer update
    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_TOP,
        PTR_DEC,
        PTR_INC
    } ptr_op_t;

    // Result value source
    typedef enum logic {
        RES_ZERO,
        RES_READ
    } res_src_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load_req;
        logic     push_write;
        logic     shift_write;
        logic     rd_en;
        rd_sel_t  rd_sel;
        ptr_op_t  ptr_op;
        logic     count_dec;
        logic     set_result;
        res_src_t res_src;
        status_t  res_status;
        logic     out_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       empty;
        logic       match;
        logic       ptr_zero;
        logic       more_above;
        logic       more_two;
        logic       out_free;
    } sts_t;

endpackage

// File: rtl/lssd_datapath.sv
// Datapath of the LIFO stack: entry memory, count, scan pointer,
// result and output registers. Depends on lssd_pkg; driven by lssd_ctrl.
module lssd_datapath
    import lssd_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  logic rsp_stall,
    input  cmd_t cmd,
    output sts_t sts,
    output logic rsp_valid,
    output rsp_t rsp
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic signed [31:0] mem [STACK_DEPTH];

    req_t               req_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      ptr_reg;
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] res_value_reg;
    status_t            res_status_reg;
    logic               out_valid_reg;
    rsp_t               out_reg;

    logic [CW-1:0]      count_m1;
    logic [AW-1:0]      top_addr;
    logic [CW:0]        ptr_ext;
    logic [CW:0]        count_ext;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    // Address arithmetic
    assign count_m1  = count_reg - CW'(1);
    assign top_addr  = count_m1[AW-1:0];
    assign ptr_ext   = (CW + 1)'(ptr_reg);
    assign count_ext = {1'b0, count_reg};

    always_comb
    begin
        case (cmd.rd_sel)
            RD_TOP:  rd_addr = top_addr;
            RD_DOWN: rd_addr = ptr_reg - AW'(1);
            RD_UP1:  rd_addr = ptr_reg + AW'(1);
            RD_UP2:  rd_addr = ptr_reg + AW'(2);
            default: rd_addr = top_addr;
        endcase
    end

    // Single write port: push on top, or move an entry down during a shift
    assign wr_en   = cmd.push_write | cmd.shift_write;
    assign wr_addr = cmd.push_write ? count_reg[AW-1:0] : ptr_reg;
    assign wr_data = cmd.push_write ? req_reg.value_in : rd_data_reg;

    // Entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.set_result)
        begin
            res_value_reg  <= (cmd.res_src == RES_READ) ? rd_data_reg : '0;
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            out_reg.value_out    <= res_value_reg;
            out_reg.status       <= res_status_reg;
            out_reg.entries_held <= 5'(count_reg);
        end
    end

    // Entry count and scan pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            if (cmd.push_write)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_m1;
            end
            case (cmd.ptr_op)
                PTR_TOP:  ptr_reg <= top_addr;
                PTR_DEC:  ptr_reg <= ptr_reg - AW'(1);
                PTR_INC:  ptr_reg <= ptr_reg + AW'(1);
                default:  ptr_reg <= ptr_reg;
            endcase
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Status to controller
    assign sts.action     = req_reg.action;
    assign sts.full       = (count_reg == CW'(STACK_DEPTH));
    assign sts.empty      = (count_reg == '0);
    assign sts.match      = (rd_data_reg == req_reg.value_in);
    assign sts.ptr_zero   = (ptr_reg == '0);
    assign sts.more_above = ((ptr_ext + (CW + 1)'(1)) < count_ext);
    assign sts.more_two   = ((ptr_ext + (CW + 1)'(2)) < count_ext);
    assign sts.out_free   = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("entry count above depth");

    // Count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + CW'(1) || count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count jumped");

    // No push write into a full stack
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_write |-> !sts.full)
        else $error("push written into full stack");

    // A full report leaves the stack at depth
    a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && res_status_reg == ST_FULL) |-> sts.full)
        else $error("full reported on a stack that is not full");

endmodule

// File: rtl/lssd_ctrl.sv
// Controller state machine for the LIFO stack: sequences push, pop,
// search and gap closing. Depends on lssd_pkg; drives lssd_datapath.
module lssd_ctrl
    import lssd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  sts_t sts,
    output logic req_stall,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_TOP;
        cmd.ptr_op     = PTR_HOLD;
        cmd.res_src    = RES_ZERO;
        cmd.res_status = ST_OK;
        req_stall      = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_FINISH;
                case (sts.action)
                    ACT_PUSH:
                    begin
                        cmd.set_result = 1'b1;
                        if (sts.full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.push_write = 1'b1;
                        end
                    end
                    ACT_POP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_result = 1'b1;
                            cmd.res_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en     = 1'b1;
                            cmd.rd_sel    = RD_TOP;
                            cmd.count_dec = 1'b1;
                            state_next    = S_POP_WAIT;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_result = 1'b1;
                            cmd.res_status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_TOP;
                            cmd.ptr_op = PTR_TOP;
                            state_next = S_SEARCH;
                        end
                    end
                    default:
                    begin
                        // unused code: no operation
                        cmd.set_result = 1'b1;
                    end
                endcase
            end

            S_POP_WAIT:
            begin
                cmd.set_result = 1'b1;
                cmd.res_src    = RES_READ;
                state_next     = S_FINISH;
            end

            // Top-down scan, one entry per cycle
            S_SEARCH:
            begin
                if (sts.match)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_src    = RES_READ;
                    if (sts.more_above)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_UP1;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        cmd.count_dec = 1'b1;
                        state_next    = S_FINISH;
                    end
                end
                else if (sts.ptr_zero)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_DOWN;
                    cmd.ptr_op = PTR_DEC;
                end
            end

            // Close the gap: move each entry above the match down one slot
            S_SHIFT:
            begin
                cmd.shift_write = 1'b1;
                cmd.ptr_op      = PTR_INC;
                if (sts.more_two)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_UP2;
                end
                else
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/lifo_stack_search_delete.sv
// LIFO stack of signed 32-bit words with push, pop and remove-by-value.
// Request channel: req_valid / req_stall / req (action, value_in).
// Response channel: rsp_valid / rsp_stall / rsp (value_out, status,
// entries_held). One response per request, in request order.
// Requests are taken one at a time; req_stall is low only while the
// block is idle. A result sits in an output register, so the next
// request is taken while that result still waits to be transferred.
// Steps from request transfer to response valid: decode, then finish for
// push, pop on empty, remove on empty and the unused code; pop adds a
// wait state for the registered read; remove adds the scan of entries from
// the top down to the match and the shift of each entry above the match.
// The entries live in a memory with one read and one write port, and the
// scan and the gap closing each handle one entry per cycle.
// Reset empties the stack; entry contents are not cleared and need not be.
// If rsp_stall is high, the response holds and the block waits with the
// next result until the output register is free.
module lifo_stack_search_delete
    import lssd_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    lssd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    // Storage and result path
    lssd_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// File: bench/lifo_stack_search_delete_test.sv
// Self-checking testbench for lifo_stack_search_delete: push, pop and remove-by-value
// against a behavioural stack, with random idling on both handshake channels.
// Depends on lssd_pkg and the lifo_stack_search_delete RTL.
`timescale 1ns / 1ps

module lifo_stack_search_delete_test
    import lssd_pkg::*;
();

    localparam int STACK_DEPTH = 16;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 60;
    // Action code with no operation behind it
    localparam logic [1:0] ACT_NONE = 2'd3;

    // One directed step: request, whether the response is written out here, and that response
    typedef struct packed {
        req_t op;
        logic typed;
        rsp_t want;
    } row_t;

    localparam rsp_t UNTYPED = '0;
    localparam int DIR_ROWS = 29;
    localparam row_t DIRECTED [DIR_ROWS] = '{
        // empty stack: pop, remove and the unused code
        {{ACT_POP,    32'sd0},       1'b1, {32'sd0, ST_EMPTY,     5'd0}},
        {{ACT_REMOVE, 32'sd5},       1'b1, {32'sd0, ST_NOT_FOUND, 5'd0}},
        {{ACT_NONE,   32'hFFFF_FFFF}, 1'b1, {32'sd0, ST_OK,       5'd0}},
        // extremes, zero, all ones, and a second copy of the maximum
        {{ACT_PUSH,   32'h8000_0000}, 1'b1, {32'sd0, ST_OK,       5'd1}},
        {{ACT_PUSH,   32'h7FFF_FFFF}, 1'b1, {32'sd0, ST_OK,       5'd2}},
        {{ACT_PUSH,   32'h0000_0000}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'hFFFF_FFFF}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'h7FFF_FFFF}, 1'b0, UNTYPED},
        // remove takes the copy nearest the top, then the bottom entry; then a miss
        {{ACT_REMOVE, 32'h7FFF_FFFF}, 1'b0, UNTYPED},
        {{ACT_REMOVE, 32'h8000_0000}, 1'b0, UNTYPED},
        {{ACT_REMOVE, 32'h0000_007B}, 1'b0, UNTYPED},
        {{ACT_POP,    32'h0000_0000}, 1'b0, UNTYPED},
        // fill up to capacity
        {{ACT_PUSH,   32'h5555_5555}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'hAAAA_AAAA}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'h0000_0001}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'hFFFF_FFFE}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'h1234_5678}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'hEDCB_A987}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'h0000_FFFF}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'hFFFF_0000}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'h00FF_00FF}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'hFF00_FF00}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'h0F0F_0F0F}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'hF0F0_F0F0}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'h3333_3333}, 1'b0, UNTYPED},
        {{ACT_PUSH,   32'hCCCC_CCCC}, 1'b0, UNTYPED},
        // refused push, then a remove that closes a gap almost the full height
        {{ACT_PUSH,   32'h0000_004D}, 1'b1, {32'sd0, ST_FULL,     5'd16}},
        {{ACT_REMOVE, 32'h0000_0000}, 1'b0, UNTYPED},
        {{ACT_POP,    32'h0000_0000}, 1'b0, UNTYPED}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Behavioural copy of the stack: slot 0 is the bottom
    logic signed [31:0] held_words [STACK_DEPTH];
    int held_count = 0;
    int peak_count = 0;

    rsp_t due_rsp [$];
    bit calm = 1'b0;
    int hold_left = 0;
    int faults = 0;
    int sent = 0;
    int checked = 0;
    int seen_status [4] = '{0, 0, 0, 0};

    lifo_stack_search_delete #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #5 clk = ~clk;

    // Apply one operation to the behavioural stack and return its response
    function automatic rsp_t stack_apply(req_t r);
        rsp_t res;
        int hit;
        res = '0;
        res.status = ST_OK;
        case (r.action)
            ACT_PUSH:
            begin
                if (held_count >= STACK_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    held_words[held_count] = r.value_in;
                    held_count++;
                end
            end
            ACT_POP:
            begin
                if (held_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    held_count--;
                    res.value_out = held_words[held_count];
                end
            end
            ACT_REMOVE:
            begin
                hit = -1;
                for (int k = held_count - 1; k >= 0; k--)
                    if (hit < 0 && held_words[k] == r.value_in)
                        hit = k;
                if (hit < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    res.value_out = held_words[hit];
                    for (int i = hit; i < held_count - 1; i++)
                        held_words[i] = held_words[i + 1];
                    held_count--;
                end
            end
            default: ;
        endcase
        res.entries_held = 5'(held_count);
        if (held_count > peak_count)
            peak_count = held_count;
        return res;
    endfunction

    // Random request; push_bias in percent steers the stack towards full or empty
    function automatic req_t pick_request(int push_bias);
        req_t r;
        int pick;
        if ($urandom_range(0, 2) == 0)
            r.value_in = $signed(32'($urandom_range(0, 7))) - 32'sd4;
        else
            r.value_in = $urandom;
        if ($urandom_range(0, 99) < push_bias)
            r.action = ACT_PUSH;
        else
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                r.action = ACT_NONE;
            else if (pick < 8)
                r.action = ACT_POP;
            else
            begin
                r.action = ACT_REMOVE;
                // mostly search for something that is there
                if (held_count > 0 && $urandom_range(0, 3) != 0)
                    r.value_in = held_words[$urandom_range(0, held_count - 1)];
            end
        end
        return r;
    endfunction

    // Offer one request after a random gap; record its expected response on transfer
    task automatic issue(input req_t r, input logic typed, input rsp_t want);
        rsp_t model_rsp;
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        model_rsp = stack_apply(r);
        due_rsp.push_back(typed ? want : model_rsp);
        sent++;
    endtask

    // Response side: random stall after each transfer, and the field checks
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp.size() == 0)
                begin
                    $error("response transfer with no request outstanding");
                    faults++;
                end
                else
                begin
                    want = due_rsp.pop_front();
                    checked++;
                    seen_status[rsp.status]++;
                    if (rsp.value_out !== want.value_out)
                    begin
                        $error("value_out: expected %0d, got %0d", want.value_out, rsp.value_out);
                        faults++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        faults++;
                    end
                    if (rsp.entries_held !== want.entries_held)
                    begin
                        $error("entries_held: expected %0d, got %0d",
                               want.entries_held, rsp.entries_held);
                        faults++;
                    end
                end
                hold_left = calm ? 0 : $urandom_range(0, 10);
            end
            else if (hold_left != 0)
                hold_left--;
            rsp_stall <= (hold_left != 0);
        end
    end

    // Stimulus and end of run
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            issue(DIRECTED[i].op, DIRECTED[i].typed, DIRECTED[i].want);

        // alternate phases drift towards full and towards empty
        for (int p = 0; p < PHASES; p++)
        begin
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue(pick_request((p % 2 == 0) ? 70 : 30), 1'b0, UNTYPED);
        end
        req_valid <= 1'b0;

        while (due_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * STACK_DEPTH + 8) @(posedge clk);

        $display("%0d requests sent, %0d responses checked, stack reached depth %0d",
                 sent, checked, peak_count);
        $display("refused pushes %0d, pops on empty %0d, failed searches %0d",
                 seen_status[ST_FULL], seen_status[ST_EMPTY], seen_status[ST_NOT_FOUND]);
        if (faults == 0)
            $display("lifo_stack_search_delete_test passed");
        else
            $display("lifo_stack_search_delete_test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("timeout with %0d responses still due", due_rsp.size());
        $display("lifo_stack_search_delete_test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/lssd_pkg.sv
rtl/lssd_datapath.sv
rtl/lssd_ctrl.sv
rtl/lifo_stack_search_delete.sv
bench/lifo_stack_search_delete_test.sv
